FILE: hw/rtl/wer_pkg.sv
// Shared types, constants and the decay table for the windowed event rate meter.
`timescale 1ns / 1ps

package wer_pkg;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] timestamp;
    } in_beat_t;

    typedef struct packed {
        logic [23:0] source_rate;
        logic [23:0] processed_rate;
        logic [16:0] queue_pressure;
        logic        event_taken;
    } out_beat_t;

    localparam logic [2:0] OP_SOURCE   = 3'd0;
    localparam logic [2:0] OP_SUBMIT   = 3'd1;
    localparam logic [2:0] OP_COMPLETE = 3'd2;
    localparam logic [2:0] OP_ABANDON  = 3'd3;
    localparam logic [2:0] OP_REPORT   = 3'd4;

    localparam logic [1:0] REG_WINDOW   = 2'd0;
    localparam logic [1:0] REG_STALE    = 2'd1;
    localparam logic [1:0] REG_CAPACITY = 2'd2;

    localparam logic [23:0] WINDOW_RESET   = 24'd500000;
    localparam logic [23:0] STALE_RESET    = 24'd750000;
    localparam logic [15:0] CAPACITY_RESET = 16'd4;
    localparam logic [23:0] MIN_WINDOW     = 24'd50000;

    localparam logic [23:0] CAA_MAX    = 24'hFFFFFF;
    localparam logic [15:0] GCOUNT_MAX = 16'hFFFF;
    localparam logic [23:0] RATE_MAX   = 24'hFFFFFF;
    localparam logic [27:0] RATE_SCALE = 28'd256000000;
    localparam logic [16:0] QP_MAX     = 17'h10000;

    localparam int DIV_W     = 52;
    localparam int DVS_W     = 32;
    localparam int DECAY_MAX = 1024;

    typedef logic [DECAY_MAX-1:0][16:0] decay_tab_t;

    // Q1.16 samples of exp(-k/32) from a Q1.32 recurrence, rounded.
    function automatic decay_tab_t build_decay();
        decay_tab_t  tab;
        logic [95:0] v;
        tab = '0;
        v   = 96'h1_0000_0000;
        for (int k = 0; k < DECAY_MAX; k++) begin
            tab[k] = 17'((v + 96'd32768) >> 16);
            v      = (v * 96'd4162825044) >> 32;
        end
        return tab;
    endfunction

endpackage

FILE: hw/rtl/wer_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module wer_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/wer_div.sv
// Shared restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module wer_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [wer_pkg::DIV_W-1:0] dividend,
    input  logic [wer_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [wer_pkg::DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(wer_pkg::DIV_W);

    logic [wer_pkg::DVS_W:0]   rem_reg;
    logic [wer_pkg::DIV_W-1:0] dq_reg;
    logic [wer_pkg::DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [wer_pkg::DVS_W:0]   shifted;
    logic                      fits;

    always_comb begin
        shifted = {rem_reg[wer_pkg::DVS_W-1:0], dq_reg[wer_pkg::DIV_W-1]};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                dq_reg   <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? shifted - {1'b0, dvs_reg} : shifted;
                dq_reg  <= {dq_reg[wer_pkg::DIV_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(wer_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

FILE: hw/rtl/windowed_event_rate_meter_unit.sv
// Top level of the windowed event rate meter: sequencer, ring state and result register.
//
//   channel  | direction | beat              | handshake
//   s_       | in        | op, timestamp     | s_valid / s_ready
//   m_       | out       | rates, pressure   | m_valid / m_ready
//   cfg_     | in        | register write    | cfg_we, no wait
//
// Each of the up to four divisions (rate, two decay indexes, queue pressure) runs on the
// shared divider, and a decayed channel adds a multiply step. Pruning and a saturated
// recount visit the ring groups one at a time through the ring RAM read port.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A new beat is taken while the previous result still waits in the output register; the
// next result then waits in the sequencer until that register is free.
`timescale 1ns / 1ps

module windowed_event_rate_meter_unit #(
    parameter int GROUP_DEPTH = 64,
    parameter int DECAY_STEPS = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wer_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wer_pkg::out_beat_t m_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_wdata
);

    localparam int SLOT_W = $clog2(GROUP_DEPTH);
    localparam int FILL_W = $clog2(GROUP_DEPTH + 1);
    localparam int ADDR_W = $clog2(2 * GROUP_DEPTH);
    localparam int K_W    = $clog2(DECAY_STEPS);
    localparam int TAB_W  = $clog2(wer_pkg::DECAY_MAX);
    localparam wer_pkg::decay_tab_t DECAY_TAB = wer_pkg::build_decay();

    typedef enum logic [4:0] {
        ST_IDLE, ST_REC, ST_FULL_DROP, ST_APPEND, ST_PRUNE_RD, ST_PRUNE_CHK,
        ST_SUM_START, ST_SUM_RD, ST_SUM_ADD, ST_SPAN_RD, ST_SPAN_CHK,
        ST_RATE_DIV, ST_RATE_WAIT, ST_AGE, ST_AGE_WAIT, ST_AGE_MUL, ST_AGE_OUT,
        ST_QP, ST_QP_WAIT, ST_DONE
    } state_t;

    state_t state_reg;

    logic [23:0] win_reg, stale_reg;
    logic [15:0] cap_reg;
    logic [SLOT_W-1:0] head_reg [2];
    logic [FILL_W-1:0] fill_reg [2];
    logic [23:0] caa_reg [2];
    logic [23:0] rate_reg [2];
    logic [31:0] last_time_reg [2];
    logic [15:0] last_cnt_reg [2];
    logic [31:0] outst_reg;

    logic        ch_reg, age_ch_reg, had_reg, resum_reg, taken_reg;
    logic [31:0] ts_reg, now_reg, span_reg;
    logic [23:0] caa_w_reg;
    logic [FILL_W-1:0] i_reg;
    logic [16:0] tab_reg;
    logic [51:0] prod_reg;
    logic [23:0] aged_reg [2];
    logic [16:0] qp_reg;
    logic        m_valid_reg;
    wer_pkg::out_beat_t m_data_reg;

    logic [23:0] w_eff, s_eff;
    logic [15:0] c_eff;
    logic [FILL_W-1:0] cur_fill;
    logic [SLOT_W-1:0] cur_head, rd_idx, wr_idx, rd_slot, wr_slot, head_inc;
    logic [SLOT_W:0]   rd_sum, wr_sum, inc_sum;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [31:0] last_t, rec_t, time_rd;
    logic [15:0] cnt_rd, cnt_wdata;
    logic        merge, tm_we, cnt_we;
    logic [23:0] drop_caa;
    logic [23:0] a_rate;
    logic [31:0] a_age;
    logic        a_plain;
    logic        div_start, div_done;
    logic [wer_pkg::DIV_W-1:0] div_dvd, div_quot;
    logic [wer_pkg::DVS_W-1:0] div_dvs;
    logic [23:0] mul_a;
    logic [27:0] mul_b;
    logic [23:0] sum_room;

    always_comb begin
        w_eff = (win_reg < wer_pkg::MIN_WINDOW) ? wer_pkg::MIN_WINDOW : win_reg;
        s_eff = (stale_reg < w_eff) ? w_eff : stale_reg;
        c_eff = (cap_reg == '0) ? 16'd1 : cap_reg;

        cur_fill = fill_reg[ch_reg];
        cur_head = head_reg[ch_reg];
        last_t   = last_time_reg[ch_reg];
        rec_t    = (cur_fill != '0 && ts_reg < last_t) ? last_t : ts_reg;
        merge    = (cur_fill != '0) && (rec_t == last_t);

        case (state_reg)
            ST_REC:    rd_idx = SLOT_W'(1);
            ST_PRUNE_RD: rd_idx = SLOT_W'(1);
            ST_SUM_RD: rd_idx = i_reg[SLOT_W-1:0];
            default:   rd_idx = '0;
        endcase

        tm_we     = 1'b0;
        cnt_we    = 1'b0;
        cnt_wdata = 16'd1;
        wr_idx    = cur_fill[SLOT_W-1:0];
        if (state_reg == ST_REC && merge) begin
            cnt_we    = last_cnt_reg[ch_reg] != wer_pkg::GCOUNT_MAX;
            cnt_wdata = last_cnt_reg[ch_reg] + 16'd1;
            wr_idx    = SLOT_W'(cur_fill - 1'b1);
        end else if (state_reg == ST_APPEND) begin
            tm_we  = 1'b1;
            cnt_we = 1'b1;
        end

        rd_sum   = {1'b0, cur_head} + {1'b0, rd_idx};
        rd_slot  = (rd_sum >= (SLOT_W+1)'(GROUP_DEPTH)) ?
                   SLOT_W'(rd_sum - (SLOT_W+1)'(GROUP_DEPTH)) : rd_sum[SLOT_W-1:0];
        wr_sum   = {1'b0, cur_head} + {1'b0, wr_idx};
        wr_slot  = (wr_sum >= (SLOT_W+1)'(GROUP_DEPTH)) ?
                   SLOT_W'(wr_sum - (SLOT_W+1)'(GROUP_DEPTH)) : wr_sum[SLOT_W-1:0];
        inc_sum  = {1'b0, cur_head} + (SLOT_W+1)'(1);
        head_inc = (inc_sum >= (SLOT_W+1)'(GROUP_DEPTH)) ?
                   SLOT_W'(inc_sum - (SLOT_W+1)'(GROUP_DEPTH)) : inc_sum[SLOT_W-1:0];
        rd_addr  = ch_reg ? ADDR_W'(GROUP_DEPTH) + ADDR_W'(rd_slot) : ADDR_W'(rd_slot);
        wr_addr  = ch_reg ? ADDR_W'(GROUP_DEPTH) + ADDR_W'(wr_slot) : ADDR_W'(wr_slot);

        if (caa_w_reg == wer_pkg::CAA_MAX) begin
            drop_caa = caa_w_reg;
        end else begin
            drop_caa = (caa_w_reg >= {8'd0, cnt_rd}) ? caa_w_reg - {8'd0, cnt_rd} : '0;
        end
        sum_room = wer_pkg::CAA_MAX - {8'd0, cnt_rd};

        a_rate  = rate_reg[age_ch_reg];
        a_age   = (now_reg > last_time_reg[age_ch_reg]) ?
                  now_reg - last_time_reg[age_ch_reg] : '0;
        a_plain = (a_rate == '0) || (fill_reg[age_ch_reg] == '0) || (a_age <= {8'd0, s_eff});

        div_start = 1'b0;
        div_dvd   = prod_reg;
        div_dvs   = span_reg;
        case (state_reg)
            ST_RATE_DIV: div_start = 1'b1;
            ST_AGE: begin
                div_start = !a_plain;
                div_dvd   = wer_pkg::DIV_W'({a_age - {8'd0, s_eff}, 5'd0});
                div_dvs   = wer_pkg::DVS_W'(w_eff);
            end
            ST_QP: begin
                div_start = 1'b1;
                div_dvd   = wer_pkg::DIV_W'({outst_reg, 16'd0});
                div_dvs   = wer_pkg::DVS_W'(c_eff);
            end
            default: ;
        endcase

        mul_a = (state_reg == ST_SPAN_CHK) ? caa_w_reg : a_rate;
        mul_b = (state_reg == ST_SPAN_CHK) ? wer_pkg::RATE_SCALE : 28'(tab_reg);
    end

    wer_ram #(.WIDTH(32), .DEPTH(2 * GROUP_DEPTH)) u_time_ram (
        .aclk(aclk), .we(tm_we), .waddr(wr_addr), .wdata(rec_t),
        .raddr(rd_addr), .rdata(time_rd)
    );

    wer_ram #(.WIDTH(16), .DEPTH(2 * GROUP_DEPTH)) u_count_ram (
        .aclk(aclk), .we(cnt_we), .waddr(wr_addr), .wdata(cnt_wdata),
        .raddr(rd_addr), .rdata(cnt_rd)
    );

    wer_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_dvd),
        .divisor(div_dvs), .done(div_done), .quotient(div_quot)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= 52'(mul_a * mul_b);
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            win_reg     <= wer_pkg::WINDOW_RESET;
            stale_reg   <= wer_pkg::STALE_RESET;
            cap_reg     <= wer_pkg::CAPACITY_RESET;
            outst_reg   <= '0;
            for (int c = 0; c < 2; c++) begin
                head_reg[c] <= '0;
                fill_reg[c] <= '0;
                caa_reg[c]  <= '0;
                rate_reg[c] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    wer_pkg::REG_WINDOW:   win_reg   <= cfg_wdata;
                    wer_pkg::REG_STALE:    stale_reg <= cfg_wdata;
                    wer_pkg::REG_CAPACITY: cap_reg   <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        ts_reg     <= s_data.timestamp;
                        now_reg    <= s_data.timestamp;
                        age_ch_reg <= 1'b0;
                        ch_reg     <= s_data.op == wer_pkg::OP_COMPLETE;
                        case (s_data.op)
                            wer_pkg::OP_SOURCE: begin
                                taken_reg <= 1'b1;
                                state_reg <= ST_REC;
                            end
                            wer_pkg::OP_SUBMIT: begin
                                taken_reg <= outst_reg != '1;
                                state_reg <= ST_AGE;
                                if (outst_reg != '1) begin
                                    outst_reg <= outst_reg + 32'd1;
                                end
                            end
                            wer_pkg::OP_COMPLETE: begin
                                taken_reg <= outst_reg != '0;
                                if (outst_reg != '0) begin
                                    outst_reg <= outst_reg - 32'd1;
                                    state_reg <= ST_REC;
                                end else begin
                                    state_reg <= ST_AGE;
                                end
                            end
                            wer_pkg::OP_ABANDON: begin
                                taken_reg <= outst_reg != '0;
                                state_reg <= ST_AGE;
                                if (outst_reg != '0) begin
                                    outst_reg <= outst_reg - 32'd1;
                                end
                            end
                            default: begin
                                taken_reg <= 1'b0;
                                state_reg <= ST_AGE;
                            end
                        endcase
                    end
                end
                ST_REC: begin
                    ts_reg    <= rec_t;
                    resum_reg <= 1'b0;
                    had_reg   <= cur_fill != '0;
                    if (merge) begin
                        if (last_cnt_reg[ch_reg] != wer_pkg::GCOUNT_MAX) begin
                            last_cnt_reg[ch_reg] <= last_cnt_reg[ch_reg] + 16'd1;
                        end
                        caa_w_reg <= (last_cnt_reg[ch_reg] != wer_pkg::GCOUNT_MAX &&
                                      cur_fill >= FILL_W'(2) &&
                                      caa_reg[ch_reg] != wer_pkg::CAA_MAX) ?
                                     caa_reg[ch_reg] + 24'd1 : caa_reg[ch_reg];
                        state_reg <= ST_PRUNE_RD;
                    end else if (cur_fill == FILL_W'(GROUP_DEPTH)) begin
                        caa_w_reg <= caa_reg[ch_reg];
                        state_reg <= ST_FULL_DROP;
                    end else begin
                        caa_w_reg <= caa_reg[ch_reg];
                        state_reg <= ST_APPEND;
                    end
                end
                ST_FULL_DROP: begin
                    caa_w_reg        <= drop_caa;
                    resum_reg        <= resum_reg | (caa_w_reg == wer_pkg::CAA_MAX);
                    head_reg[ch_reg] <= head_inc;
                    fill_reg[ch_reg] <= cur_fill - 1'b1;
                    state_reg        <= ST_APPEND;
                end
                ST_APPEND: begin
                    fill_reg[ch_reg]      <= cur_fill + 1'b1;
                    last_time_reg[ch_reg] <= ts_reg;
                    last_cnt_reg[ch_reg]  <= 16'd1;
                    if (had_reg && caa_w_reg != wer_pkg::CAA_MAX) begin
                        caa_w_reg <= caa_w_reg + 24'd1;
                    end
                    state_reg <= ST_PRUNE_RD;
                end
                ST_PRUNE_RD: begin
                    state_reg <= (cur_fill > FILL_W'(2)) ? ST_PRUNE_CHK : ST_SUM_START;
                end
                ST_PRUNE_CHK: begin
                    if ({1'b0, time_rd} + {9'd0, w_eff} < {1'b0, ts_reg}) begin
                        caa_w_reg        <= drop_caa;
                        resum_reg        <= resum_reg | (caa_w_reg == wer_pkg::CAA_MAX);
                        head_reg[ch_reg] <= head_inc;
                        fill_reg[ch_reg] <= cur_fill - 1'b1;
                        state_reg        <= ST_PRUNE_RD;
                    end else begin
                        state_reg <= ST_SUM_START;
                    end
                end
                ST_SUM_START: begin
                    if (resum_reg) begin
                        caa_w_reg <= '0;
                        i_reg     <= FILL_W'(1);
                        state_reg <= ST_SUM_RD;
                    end else begin
                        state_reg <= ST_SPAN_RD;
                    end
                end
                ST_SUM_RD: begin
                    state_reg <= (i_reg < cur_fill) ? ST_SUM_ADD : ST_SPAN_RD;
                end
                ST_SUM_ADD: begin
                    if (caa_w_reg > sum_room) begin
                        caa_w_reg <= wer_pkg::CAA_MAX;
                        state_reg <= ST_SPAN_RD;
                    end else begin
                        caa_w_reg <= caa_w_reg + {8'd0, cnt_rd};
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_SUM_RD;
                    end
                end
                ST_SPAN_RD: begin
                    caa_reg[ch_reg] <= caa_w_reg;
                    state_reg       <= (cur_fill >= FILL_W'(2)) ? ST_SPAN_CHK : ST_AGE;
                end
                ST_SPAN_CHK: begin
                    span_reg  <= ts_reg - time_rd;
                    state_reg <= ((ts_reg - time_rd) > 32'd1 && caa_w_reg != '0) ?
                                 ST_RATE_DIV : ST_AGE;
                end
                ST_RATE_DIV: begin
                    state_reg <= ST_RATE_WAIT;
                end
                ST_RATE_WAIT: begin
                    if (div_done) begin
                        rate_reg[ch_reg] <= (div_quot[51:24] != '0) ?
                                            wer_pkg::RATE_MAX : div_quot[23:0];
                        state_reg        <= ST_AGE;
                    end
                end
                ST_AGE: begin
                    if (a_plain) begin
                        aged_reg[age_ch_reg] <= a_rate;
                        age_ch_reg           <= 1'b1;
                        state_reg            <= age_ch_reg ? ST_QP : ST_AGE;
                    end else begin
                        state_reg <= ST_AGE_WAIT;
                    end
                end
                ST_AGE_WAIT: begin
                    if (div_done) begin
                        if (div_quot >= wer_pkg::DIV_W'(DECAY_STEPS)) begin
                            aged_reg[age_ch_reg] <= '0;
                            age_ch_reg           <= 1'b1;
                            state_reg            <= age_ch_reg ? ST_QP : ST_AGE;
                        end else begin
                            tab_reg   <= DECAY_TAB[TAB_W'(div_quot[K_W-1:0])];
                            state_reg <= ST_AGE_MUL;
                        end
                    end
                end
                ST_AGE_MUL: begin
                    state_reg <= ST_AGE_OUT;
                end
                ST_AGE_OUT: begin
                    aged_reg[age_ch_reg] <= prod_reg[39:16];
                    age_ch_reg           <= 1'b1;
                    state_reg            <= age_ch_reg ? ST_QP : ST_AGE;
                end
                ST_QP: begin
                    state_reg <= ST_QP_WAIT;
                end
                ST_QP_WAIT: begin
                    if (div_done) begin
                        qp_reg    <= (div_quot > wer_pkg::DIV_W'(wer_pkg::QP_MAX)) ?
                                     wer_pkg::QP_MAX : div_quot[16:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                   <= 1'b1;
                        m_data_reg.source_rate    <= aged_reg[0];
                        m_data_reg.processed_rate <= aged_reg[1];
                        m_data_reg.queue_pressure <= qp_reg;
                        m_data_reg.event_taken    <= taken_reg;
                        state_reg                     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
